FILE: rtl/convolutional_byte_interleaver_defines.svh
// Assertion macros shared by the convolutional byte interleaver RTL.
`ifndef CONVOLUTIONAL_BYTE_INTERLEAVER_DEFINES_SVH
`define CONVOLUTIONAL_BYTE_INTERLEAVER_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define CBI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("interleaver assertion failed");

// Antecedent implies consequent in the next cycle.
`define CBI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("interleaver assertion failed");

`else

`define CBI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define CBI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/cbi_pkg.sv
// Types and constants shared by the convolutional byte interleaver.
`default_nettype none

package cbi_pkg;

    localparam int DATA_W = 8;

    typedef logic [DATA_W-1:0] byte_t;

endpackage

`default_nettype wire

FILE: rtl/cbi_channels.sv
// Valid/ready channel interfaces for the interleaver input and output bytes.
`default_nettype none

interface cbi_in_if;
    logic           valid;
    logic           ready;
    cbi_pkg::byte_t data_in;

    modport source (output valid, output data_in, input ready);
    modport sink (input valid, input data_in, output ready);
endinterface

interface cbi_out_if;
    logic           valid;
    logic           ready;
    cbi_pkg::byte_t data_out;

    modport source (output valid, output data_out, input ready);
    modport sink (input valid, input data_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/cbi_cell.sv
// One delay cell: a short byte shift segment that advances on its shift enable.
`default_nettype none

module cbi_cell #(
    parameter int DEPTH = 12
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           shift,
    input  wire cbi_pkg::byte_t din,
    output cbi_pkg::byte_t      dout
);

    cbi_pkg::byte_t stage_reg [DEPTH];

    // Advance the segment by one byte; storage starts out zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                stage_reg[k] <= '0;
            end
        end
        else if (shift)
        begin
            stage_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                stage_reg[k] <= stage_reg[k-1];
            end
        end
    end

    // Hand the oldest byte to the neighbor
    assign dout = stage_reg[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/cbi_branch.sv
// One interleaver branch: a chain of delay cells that all advance together.
`default_nettype none

module cbi_branch #(
    parameter int CELLS      = 1,
    parameter int UNIT_DEPTH = 12
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           shift,
    input  wire cbi_pkg::byte_t din,
    output cbi_pkg::byte_t      dout
);

    cbi_pkg::byte_t link [CELLS+1];

    assign link[0] = din;

    // Chain the cells head to tail
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        cbi_cell #(
            .DEPTH (UNIT_DEPTH)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .din   (link[k]),
            .dout  (link[k+1])
        );
    end

    assign dout = link[CELLS];

endmodule

`default_nettype wire

FILE: rtl/convolutional_byte_interleaver.sv
// Top level of the convolutional byte interleaver: branch select, branches, output register.
//
//   channel | dir | payload        | handshake
//   feed    | in  | data_in  [7:0] | valid/ready
//   result  | out | data_out [7:0] | valid/ready
//
// A byte is taken per clock unless result stalls; its result is registered the cycle after.
// Branch j is j chained cells of UNIT_DEPTH bytes each, shifted only when that branch is
// selected, so the byte read out is the one written j*UNIT_DEPTH visits earlier.
// Reset clears every delay byte and the branch select at once; no clearing pass is needed.
// A stalled result holds the output register; feed is taken whenever that register is free
// or being emptied in the same cycle.
`default_nettype none
`include "convolutional_byte_interleaver_defines.svh"

module convolutional_byte_interleaver #(
    parameter int BRANCHES   = 12,
    parameter int UNIT_DEPTH = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cbi_in_if.sink    feed,
    cbi_out_if.source result
);

    localparam int SEL_W = $clog2(BRANCHES);

    logic             accept;
    logic [SEL_W-1:0] sel_reg;
    logic [SEL_W-1:0] sel_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    cbi_pkg::byte_t   data_out_reg;
    cbi_pkg::byte_t   branch_out [BRANCHES];
    logic             branch_shift [BRANCHES];

    // Take a transaction whenever the output register is free or draining
    assign feed.ready = !out_valid_reg || result.ready;
    assign accept     = feed.valid && feed.ready;

    // Advance the round-robin branch select, wrapping at the last branch
    always_comb
    begin
        sel_next = sel_reg;
        if (accept)
        begin
            if (sel_reg == SEL_W'(BRANCHES - 1))
            begin
                sel_next = '0;
            end
            else
            begin
                sel_next = sel_reg + SEL_W'(1);
            end
        end
    end

    // Branch zero passes the byte straight through
    assign branch_out[0]   = feed.data_in;
    assign branch_shift[0] = 1'b0;

    // Build the delayed branches
    for (genvar j = 1; j < BRANCHES; j++)
    begin : g_branch
        assign branch_shift[j] = accept && (sel_reg == SEL_W'(j));

        cbi_branch #(
            .CELLS      (j),
            .UNIT_DEPTH (UNIT_DEPTH)
        ) u_branch (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (branch_shift[j]),
            .din   (feed.data_in),
            .dout  (branch_out[j])
        );
    end

    // Hold the result until taken, reload on every accepted transaction
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the selected branch output
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg <= branch_out[sel_reg];
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.data_out = data_out_reg;

    // Checks on branch sequencing and pass-through timing
    `CBI_ASSERT_NEXT(a_pass_through, clk, rst_n, accept && (sel_reg == '0), result.valid && (result.data_out == $past(feed.data_in)))
    `CBI_ASSERT_NEXT(a_sel_wrap, clk, rst_n, accept && (sel_reg == SEL_W'(BRANCHES - 1)), sel_reg == '0)
    `CBI_ASSERT_NEXT(a_sel_hold, clk, rst_n, !accept, $stable(sel_reg))
    `CBI_ASSERT_NEXT(a_result_loaded, clk, rst_n, accept, out_valid_reg)

endmodule

`default_nettype wire

FILE: tb/sv/convolutional_byte_interleaver_tb.sv
// Self-checking testbench for the convolutional byte interleaver with random handshake gaps.
`timescale 1ns / 100ps

module convolutional_byte_interleaver_tb;

    localparam int BRANCHES    = 12;
    localparam int UNIT_DEPTH  = 12;
    localparam int STORE_BYTES = UNIT_DEPTH * BRANCHES * (BRANCHES - 1) / 2;
    localparam int RANDOM_BYTES = 1600;
    localparam int MAX_WAIT    = 10;
    localparam int DRAIN_CYCLES = 16;

    logic clk;
    logic rst_n;

    cbi_in_if  feed_ch ();
    cbi_out_if result_ch ();

    convolutional_byte_interleaver #(
        .BRANCHES   (BRANCHES),
        .UNIT_DEPTH (UNIT_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (result_ch)
    );

    // Shadow copy of the interleaver state
    int             lane_sel;
    int             lane_pos [BRANCHES];
    cbi_pkg::byte_t delay_mem [STORE_BYTES];

    cbi_pkg::byte_t send_bytes [$];
    cbi_pkg::byte_t expected_bytes [$];
    int             total_bytes;
    int             accepted_count;
    int             error_count;

    bit             feed_fired;
    bit             out_fired;
    bit             feed_hold;
    cbi_pkg::byte_t feed_byte;
    int             feed_gap;
    bit             feed_quiet;
    int             out_stall;
    bit             out_quiet;

    // Predict the byte that leaves for one byte that enters, and advance the state
    function automatic cbi_pkg::byte_t interleave_byte(input cbi_pkg::byte_t byte_in);
        cbi_pkg::byte_t byte_out;
        int             span;
        int             base;
        int             at;
        if (lane_sel == 0)
        begin
            byte_out = byte_in;
        end
        else
        begin
            span = UNIT_DEPTH * lane_sel;
            base = UNIT_DEPTH * lane_sel * (lane_sel - 1) / 2;
            at = base + lane_pos[lane_sel];
            byte_out = delay_mem[at];
            delay_mem[at] = byte_in;
            lane_pos[lane_sel] = (lane_pos[lane_sel] + 1 == span) ? 0 : lane_pos[lane_sel] + 1;
        end
        lane_sel = (lane_sel + 1 == BRANCHES) ? 0 : lane_sel + 1;
        return byte_out;
    endfunction

    // Draw the idle cycles before the next transaction; quiet stretches have none
    function automatic int pick_wait(input bit quiet);
        if (quiet)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    always #1 clk = ~clk;

    // Sample both channels, check results, predict accepted bytes
    always @(posedge clk)
    begin
        cbi_pkg::byte_t want;
        feed_fired <= rst_n && feed_ch.valid && feed_ch.ready;
        out_fired  <= rst_n && result_ch.valid && result_ch.ready;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t ns: unexpected data_out transaction, expected none, got %02h",
                         $time, result_ch.data_out);
                error_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (result_ch.data_out !== want)
                begin
                    $display("%0t ns: data_out mismatch, expected %02h, got %02h",
                             $time, want, result_ch.data_out);
                    error_count++;
                end
            end
        end
        if (rst_n && feed_ch.valid && feed_ch.ready)
        begin
            expected_bytes.push_back(interleave_byte(feed_ch.data_in));
            accepted_count++;
        end
    end

    // Drive input bytes with random gaps between transactions
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            feed_hold = 0;
            feed_gap = 0;
            feed_ch.valid <= 1'b0;
            feed_ch.data_in <= '0;
        end
        else
        begin
            if (feed_fired)
            begin
                feed_hold = 0;
            end
            if (!feed_hold)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                end
                else if (send_bytes.size() > 0)
                begin
                    feed_byte = send_bytes.pop_front();
                    feed_hold = 1;
                    if ($urandom_range(0, 39) == 0)
                    begin
                        feed_quiet = !feed_quiet;
                    end
                    feed_gap = pick_wait(feed_quiet);
                end
            end
            feed_ch.valid <= feed_hold;
            feed_ch.data_in <= feed_byte;
        end
    end

    // Stall the result side at random after each transaction
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall = 0;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_fired)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    out_quiet = !out_quiet;
                end
                out_stall = pick_wait(out_quiet);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        cbi_pkg::byte_t directed [24];
        clk = 1'b0;
        rst_n = 1'b0;
        feed_ch.valid = 1'b0;
        feed_ch.data_in = '0;
        result_ch.ready = 1'b0;
        feed_fired = 0;
        out_fired = 0;
        feed_hold = 0;
        feed_byte = '0;
        feed_gap = 0;
        feed_quiet = 0;
        out_stall = 0;
        out_quiet = 0;
        accepted_count = 0;
        error_count = 0;
        lane_sel = 0;
        foreach (lane_pos[i]) lane_pos[i] = 0;
        foreach (delay_mem[i]) delay_mem[i] = '0;

        // Extremes, walking ones and zeros; two rounds put a value on every branch
        directed = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h04, 8'h08,
                     8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7,
                     8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h00, 8'hFF, 8'h0F, 8'hF0};
        foreach (directed[i]) send_bytes.push_back(directed[i]);
        // Enough random bytes that even the longest branch wraps; the count leaves
        // the round-robin mid-group at the end
        for (int i = 0; i < RANDOM_BYTES; i++)
        begin
            send_bytes.push_back(cbi_pkg::byte_t'($urandom_range(0, 255)));
        end
        total_bytes = send_bytes.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_bytes || expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
